### rtl/wra_pkg.sv
// Shared types and constants for the warm-up running average block.
package wra_pkg;

	// Fixed field widths
	localparam int AVG_W = 24;
	localparam int WIN_W = 7;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(2);

	// Shared adder operation
	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// Sequencer phase strobes to the datapath
	typedef struct packed {
		logic idle;
		logic mul;
		logic addx;
		logic absv;
		logic div;
		logic fin;
	} wra_ctl_t;

endpackage

### rtl/wra_alu.sv
// Shared add/subtract unit with a sign-extended result one bit wider.
module wra_alu #(
	parameter int W = 32
) (
	input  wra_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [W:0]       res
);
	import wra_pkg::*;

	logic         sub;
	logic [W:0]   b_ext;

	// Two's complement add; subtract by inverted operand and carry in
	assign sub   = (op == ALU_SUB);
	assign b_ext = sub ? ~{b[W-1], b} : {b[W-1], b};
	assign res   = {a[W-1], a} + b_ext + {{W{1'b0}}, sub};

endmodule

### rtl/wra_seq.sv
// Sequencer: steps one sample through multiply, add, absolute value, divide and finish phases.
module wra_seq #(
	parameter int NUM_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              fin_ok,
	output wra_pkg::wra_ctl_t ctl
);
	import wra_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_ADDX = 6'b000100,
		S_ABS  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	// Phase state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
						cnt_q   <= CNT_W'(WIN_W - 1);
					end
				end
				S_MUL: begin
					if (cnt_q == '0) state_q <= S_ADDX;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_ADDX: state_q <= S_ABS;
				S_ABS: begin
					state_q <= S_DIV;
					cnt_q   <= CNT_W'(NUM_W - 1);
				end
				S_DIV: begin
					if (cnt_q == '0) state_q <= S_FIN;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_FIN: begin
					if (fin_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Strobes; finish only fires when the output register can take the word
	assign ctl.idle = (state_q == S_IDLE);
	assign ctl.mul  = (state_q == S_MUL);
	assign ctl.addx = (state_q == S_ADDX);
	assign ctl.absv = (state_q == S_ABS);
	assign ctl.div  = (state_q == S_DIV);
	assign ctl.fin  = (state_q == S_FIN) && fin_ok;

endmodule

### rtl/warmup_running_average.sv
// Warm-up running average: mean of the first samples, then first-order IIR.
//
//  channel  | signals                        | direction
//  ---------+--------------------------------+----------
//  in       | in_valid, in_ready, sample     | sink
//  out      | out_valid, out_ready, average  | source
//  cfg      | cfg_valid, cfg_ready, cfg_data | sink (window)
//
// A sample runs from accept to a valid result through a shift-add multiply over the 7
// bits of the divisor minus one, an add of the scaled sample, an absolute value, then
// one restoring quotient bit per cycle and a clamped signed finish, all through one shared adder.
// in_ready is high only while the sequencer is idle; the finish step waits
// while the output register still holds an untaken word.
// Reset clears window to 2, the sample count and the average to zero.
module warmup_running_average #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [wra_pkg::AVG_W-1:0] average,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wra_pkg::WIN_W-1:0]       cfg_data
);
	import wra_pkg::*;

	// Numerator width: old * (d-1) plus scaled sample, with a sign bit
	localparam int PROD_W = AVG_W + WIN_W;
	localparam int XS_W   = SAMPLE_BITS + FRAC_BITS + 1;
	localparam int NUM_W  = ((PROD_W > XS_W) ? PROD_W : XS_W) + 1;

	localparam logic [NUM_W:0] SAT_HI = {{(NUM_W+2-AVG_W){1'b0}}, {(AVG_W-1){1'b1}}};
	localparam logic [NUM_W:0] SAT_LO = {{(NUM_W+2-AVG_W){1'b1}}, {(AVG_W-1){1'b0}}};

	wra_ctl_t ctl;

	logic                   in_fire;
	logic                   fin_ok;
	logic [WIN_W-1:0]       window_q;
	logic [WIN_W-1:0]       count_q;
	logic [AVG_W-1:0]       avg_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [NUM_W-1:0]       acc_q;
	logic [NUM_W-1:0]       mcand_q;
	logic [WIN_W-1:0]       mult_q;
	logic [WIN_W-1:0]       div_q;
	logic [WIN_W-1:0]       rem_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [AVG_W-1:0]       average_q;

	logic [WIN_W-1:0]       w_eff;
	logic [WIN_W-1:0]       d_new;
	logic [WIN_W-1:0]       count_new;
	logic [NUM_W-1:0]       x_ext;
	logic [WIN_W:0]         rem_shift;
	alu_op_t                alu_op;
	logic [NUM_W-1:0]       alu_a;
	logic [NUM_W-1:0]       alu_b;
	logic [NUM_W:0]         alu_res;
	logic [AVG_W-1:0]       sat_val;

	assign in_ready  = ctl.idle;
	assign in_fire   = in_valid && ctl.idle;
	assign cfg_ready = 1'b1;
	assign fin_ok    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign average   = average_q;

	// Divisor and next count chosen at accept
	always_comb begin
		w_eff = (window_q == '0) ? WIN_W'(1) : window_q;
		if (count_q == w_eff) begin
			count_new = count_q;
			d_new     = w_eff;
		end else if (count_q < w_eff) begin
			count_new = count_q + 1'b1;
			d_new     = count_q + 1'b1;
		end else begin
			count_new = WIN_W'(1);
			d_new     = WIN_W'(1);
		end
	end

	// Scaled sample and partial remainder with the next dividend bit
	assign x_ext     = {{(NUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q} << FRAC_BITS;
	assign rem_shift = {rem_q, acc_q[NUM_W-1]};

	// Operand selection for the shared adder
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = acc_q;
		alu_b  = '0;
		if (ctl.mul) begin
			alu_b = mult_q[0] ? mcand_q : '0;
		end else if (ctl.addx) begin
			alu_b = x_ext;
		end else if (ctl.absv) begin
			alu_a  = '0;
			alu_b  = acc_q;
			alu_op = acc_q[NUM_W-1] ? ALU_SUB : ALU_ADD;
		end else if (ctl.div) begin
			alu_a  = {{(NUM_W-WIN_W-1){1'b0}}, rem_shift};
			alu_b  = {{(NUM_W-WIN_W){1'b0}}, div_q};
			alu_op = ALU_SUB;
		end else begin
			alu_a  = '0;
			alu_b  = acc_q;
			alu_op = neg_q ? ALU_SUB : ALU_ADD;
		end
	end

	wra_alu #(.W(NUM_W)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// Clamp the signed quotient to the average range
	always_comb begin
		if ($signed(alu_res) > $signed(SAT_HI)) sat_val = SAT_HI[AVG_W-1:0];
		else if ($signed(alu_res) < $signed(SAT_LO)) sat_val = SAT_LO[AVG_W-1:0];
		else sat_val = alu_res[AVG_W-1:0];
	end

	wra_seq #(.NUM_W(NUM_W)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid),
		.fin_ok (fin_ok),
		.ctl    (ctl)
	);

	// Filter state, window register and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			count_q     <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) window_q <= cfg_data;
			if (in_fire) count_q <= count_new;
			if (ctl.fin) begin
				avg_q       <= sat_val;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= sample;
			acc_q    <= '0;
			mcand_q  <= {{(NUM_W-AVG_W){avg_q[AVG_W-1]}}, avg_q};
			mult_q   <= d_new - 1'b1;
			div_q    <= d_new;
			rem_q    <= '0;
		end
		if (ctl.mul) begin
			acc_q   <= alu_res[NUM_W-1:0];
			mcand_q <= mcand_q << 1;
			mult_q  <= mult_q >> 1;
		end
		if (ctl.addx) acc_q <= alu_res[NUM_W-1:0];
		if (ctl.absv) begin
			neg_q <= acc_q[NUM_W-1];
			acc_q <= alu_res[NUM_W-1:0];
		end
		// Restoring step: quotient bit shifts into the dividend register
		if (ctl.div) begin
			acc_q <= {acc_q[NUM_W-2:0], ~alu_res[NUM_W]};
			rem_q <= alu_res[NUM_W] ? rem_shift[WIN_W-1:0] : alu_res[WIN_W-1:0];
		end
		if (ctl.fin) average_q <= sat_val;
	end

endmodule

### rtl/wra_check.sv
// Port-level assertions for the warm-up running average, bound to the top.
module wra_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [wra_pkg::AVG_W-1:0]  average
);
	import wra_pkg::*;

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average))
		else $error("result word changed while stalled");

	// An accepted sample keeps the block busy, with input ready low, at the start of the multiply phase
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input ready while a sample is in work");

	// A new result appears only as the block returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while busy");

endmodule

bind warmup_running_average wra_check u_wra_check (.*);
